[hw/rtl/b64d_pkg.sv]
`default_nettype none
package b64d_pkg;

  // Width of the decoded length reported with a status.
  localparam int unsigned LenW = 16;

  // Default depth of the record queue between front and back.
  localparam int unsigned B64D_FIFO_DEPTH = 4;

  // Default width of the decoded byte counter.
  localparam int unsigned B64D_COUNT_BITS = 16;

  // Reset value of the output limit register.
  localparam logic [15:0] B64D_LIMIT_RESET = 16'd128;

  // Register index of the limit register (paddr bit 2).
  localparam logic REG_MAX_OUTPUT_BYTES = 1'b0;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEN  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_BAD_CHAR = 2'd3;

  // Alphabet characters and sextet offsets.
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PAD     = 8'h3D;
  localparam logic [5:0] OFS_LOWER  = 6'd26;
  localparam logic [5:0] OFS_DIGIT  = 6'd52;
  localparam logic [5:0] SX_PLUS    = 6'd62;
  localparam logic [5:0] SX_SLASH   = 6'd63;

  // One queue record: the bytes of a group and an optional status.
  typedef struct packed {
    logic [23:0]     word;
    logic [1:0]      nbytes;
    logic            has_status;
    logic [1:0]      code;
    logic [LenW-1:0] len;
  } b64d_rec_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } b64d_qstat_t;

  // Maps a character to {bad, sextet}; the pad character maps to zero.
  function automatic logic [6:0] b64d_sextet(input logic [7:0] ch);
    logic [7:0] diff;
    logic [6:0] r;
    diff = 8'd0;
    r    = 7'b1000000;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      diff = ch - CH_UPPER_A;
      r    = {1'b0, diff[5:0]};
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      diff = ch - CH_LOWER_A;
      r    = {1'b0, diff[5:0] + OFS_LOWER};
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      diff = ch - CH_ZERO;
      r    = {1'b0, diff[5:0] + OFS_DIGIT};
    end else if (ch == CH_PLUS) begin
      r = {1'b0, SX_PLUS};
    end else if (ch == CH_SLASH) begin
      r = {1'b0, SX_SLASH};
    end else if (ch == CH_PAD) begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/base64_stream_decoder.sv]
// With nothing queued ahead, the first result of an item is written to the record
// queue at its input transfer, then loaded into the output register, raising tvalid.
// Throughput: one character per cycle in while the queue has room, one result per
// cycle out while the sink is ready; a final character yields up to four results,
// absorbed by a FIFO_DEPTH-record queue. Reset (rst_ni, async, active low) clears the
// stream state, queue, tvalid, and sets max_output_bytes to 128. No clearing pass.
`default_nettype none
module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int unsigned COUNT_BITS = B64D_COUNT_BITS,
  parameter int unsigned FIFO_DEPTH = B64D_FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Character stream in.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tlast,   // end_of_string
  // Result stream out.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] data_byte, [9:8] status_code,
                                           // [25:10] decoded_length, [31:26] zero
  output logic             m_axis_tuser,   // is_status
  output logic             m_axis_tlast,   // last_of_run
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] limit_q;
  logic        accept;
  logic        push;
  logic        pop;
  b64d_rec_t   rec;
  b64d_rec_t   head;
  b64d_qstat_t qstat;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_OUTPUT_BYTES) ? {16'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= B64D_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_MAX_OUTPUT_BYTES)) begin
      limit_q <= pwdata[15:0];
    end
  end

  // Input transfer is taken whenever the queue has room.
  assign s_axis_tready = !qstat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  b64d_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .limit_i  (limit_q),
    .push_o   (push),
    .rec_o    (rec)
  );

  b64d_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!qstat.empty),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (m_axis_tdata),
    .m_user_o     (m_axis_tuser),
    .m_last_o     (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // A final character always leaves a record for its status.
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |-> push)
    else $error("final character did not push a status record");

  // A status is always the last result of its item.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("status result without last_of_run");

  // A data byte carries zero status fields.
  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[31:8] == 24'd0))
    else $error("data result with nonzero status fields");
`endif

endmodule
`default_nettype wire

[hw/rtl/b64d_front.sv]
`default_nettype none
module b64d_front
  import b64d_pkg::*;
#(
  parameter int unsigned COUNT_BITS = B64D_COUNT_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  char_i,
  input  wire logic        last_i,
  input  wire logic [15:0] limit_i,
  output logic             push_o,
  output b64d_rec_t        rec_o
);

  logic [1:0]            pos_q, pos_d;
  logic [17:0]           held_q, held_d;
  logic                  prev_pad_q, prev_pad_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic                  bad_q, bad_d;

  logic [6:0]            sx;
  logic                  is_pad;
  logic                  bad_now;
  logic [1:0]            keep;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] total_new;
  logic [COUNT_BITS+15:0] total_ext;
  logic [COUNT_BITS+15:0] limit_ext;
  logic [COUNT_BITS+15:0] len_ext;

  // Classify the character.
  assign sx      = b64d_sextet(char_i);
  assign is_pad  = (char_i == CH_PAD);
  assign bad_now = bad_q | sx[6];

  // Bytes kept by a completed group; padding trims the final one.
  always_comb begin
    keep = 2'd3;
    if (last_i) begin
      keep = 2'd3 - {1'b0, is_pad} - {1'b0, prev_pad_q};
    end
  end

  // Saturating byte count.
  assign sum       = {1'b0, total_q} + {{(COUNT_BITS-1){1'b0}}, keep};
  assign total_new = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
  assign total_ext = {16'd0, total_new};
  assign limit_ext = {{COUNT_BITS{1'b0}}, limit_i};

  // State update and record for the queue.
  always_comb begin
    pos_d      = pos_q;
    held_d     = held_q;
    prev_pad_d = prev_pad_q;
    total_d    = total_q;
    bad_d      = bad_q;
    push_o     = 1'b0;
    len_ext    = {16'd0, total_q};
    rec_o      = '0;
    rec_o.word = {held_q, sx[5:0]};
    if (accept_i) begin
      bad_d      = bad_now;
      prev_pad_d = is_pad;
      if (pos_q == 2'd3) begin
        total_d      = total_new;
        pos_d        = 2'd0;
        held_d       = 18'd0;
        rec_o.nbytes = bad_now ? 2'd0 : keep;
        len_ext      = total_ext;
        if (last_i) begin
          rec_o.has_status = 1'b1;
          if (total_ext > limit_ext) begin
            rec_o.code = ST_TOO_LONG;
          end else if (bad_now) begin
            rec_o.code = ST_BAD_CHAR;
          end else begin
            rec_o.code = ST_OK;
          end
        end
      end else begin
        held_d = {held_q[11:0], sx[5:0]};
        pos_d  = pos_q + 2'd1;
        if (last_i) begin
          rec_o.has_status = 1'b1;
          rec_o.code       = ST_BAD_LEN;
        end
      end
      push_o = (rec_o.nbytes != 2'd0) || last_i;
      // The final character starts a fresh string.
      if (last_i) begin
        pos_d      = 2'd0;
        held_d     = 18'd0;
        prev_pad_d = 1'b0;
        total_d    = '0;
        bad_d      = 1'b0;
      end
    end
    rec_o.len = len_ext[15:0];
  end

  // Stream state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 2'd0;
      held_q     <= 18'd0;
      prev_pad_q <= 1'b0;
      total_q    <= '0;
      bad_q      <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      held_q     <= held_d;
      prev_pad_q <= prev_pad_d;
      total_q    <= total_d;
      bad_q      <= bad_d;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/b64d_fifo.sv]
`default_nettype none
module b64d_fifo
  import b64d_pkg::*;
#(
  parameter int unsigned DEPTH = B64D_FIFO_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire b64d_rec_t  rec_i,
  input  wire logic       pop_i,
  output b64d_rec_t       head_o,
  output b64d_qstat_t     stat_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  b64d_rec_t     mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          do_push;
  logic          do_pop;

  assign stat_o.full  = (cnt_q == (AW+1)'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  // Pointer and fill count update with explicit wrap.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Record storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/b64d_back.sv]
`default_nettype none
module b64d_back
  import b64d_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire b64d_rec_t   head_i,
  input  wire logic        head_valid_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output logic [31:0]      m_data_o,
  output logic             m_user_o,
  output logic             m_last_o
);

  logic [1:0]  idx_q, idx_d;
  logic        valid_q, valid_d;
  logic [31:0] data_q, data_d;
  logic        user_q, user_d;
  logic        last_q, last_d;
  logic [2:0]  res_total;
  logic        res_last;
  logic        load;
  logic [7:0]  byte_sel;

  assign res_total = {1'b0, head_i.nbytes} + {2'b00, head_i.has_status};
  assign res_last  = ({1'b0, idx_q} + 3'd1) == res_total;
  assign load      = head_valid_i && (!valid_q || m_ready_i);
  assign pop_o     = load && res_last;

  // Byte of the group word picked by the result index.
  always_comb begin
    case (idx_q)
      2'd0:    byte_sel = head_i.word[23:16];
      2'd1:    byte_sel = head_i.word[15:8];
      default: byte_sel = head_i.word[7:0];
    endcase
  end

  // Output register: loaded from the queue head one result at a transfer.
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q && !m_ready_i;
    data_d  = data_q;
    user_d  = user_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      last_d  = res_last;
      idx_d   = res_last ? 2'd0 : idx_q + 2'd1;
      if (idx_q < head_i.nbytes) begin
        user_d = 1'b0;
        data_d = {24'd0, byte_sel};
      end else begin
        user_d = 1'b1;
        data_d = {6'd0, head_i.len, head_i.code, 8'd0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    user_q <= user_d;
    last_q <= last_d;
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_user_o  = user_q;
  assign m_last_o  = last_q;

endmodule
`default_nettype wire
